/* hw/rtl/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg: sliding window median filter package
// Payload types, cell control and fixed constants shared by the filter files.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 33;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] RESET_WINDOW_SIZE = 5'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] sample;
    logic                   first;
  } in_item_t;

  typedef logic signed [OUT_W-1:0] median_t;
  typedef logic [CFG_W-1:0]        cfg_t;

  // per-request control broadcast to the cell row
  typedef struct packed {
    logic upd;
    logic full;
  } cell_ctrl_t;

endpackage

/* hw/rtl/swmf_stream_if.sv */
// ----------------------------------------------------------------------------
// swmf_stream_if: valid/ready channel
// Carries one request of payload type T from a source to a sink.
// ----------------------------------------------------------------------------
interface swmf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/swmf_cell.sv */
// ----------------------------------------------------------------------------
// swmf_cell: one slot of the sorted window
// Holds one sample and its age. Per update the row drops the expired sample,
// closes the gap and opens a slot for the new sample in sorted position.
// ----------------------------------------------------------------------------
module swmf_cell import swmf_pkg::*; #(
  parameter int SW = 32,
  parameter int AW = 4
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic signed [SW-1:0] sample_i,
  input  logic [AW-1:0]        age_last_i,
  input  logic                 own_vld_i,
  input  logic                 right_vld_i,
  input  logic signed [SW-1:0] right_val_i,
  input  logic [AW-1:0]        right_age_i,
  input  logic                 del_seen_i,
  input  logic                 left_gt_i,
  input  logic signed [SW-1:0] left_rval_i,
  input  logic [AW-1:0]        left_rage_i,
  output logic signed [SW-1:0] val_o,
  output logic [AW-1:0]        age_o,
  output logic signed [SW-1:0] rval_o,
  output logic [AW-1:0]        rage_o,
  output logic                 gt_o,
  output logic                 del_seen_o
);

  logic signed [SW-1:0] val_q, val_d;
  logic [AW-1:0]        age_q, age_d;
  logic                 del, del_le, rvld;

  assign del        = ctrl_i.full && own_vld_i && (age_q == age_last_i);
  assign del_le     = del_seen_i || del;
  assign del_seen_o = del_le;

  // window with the expired sample removed
  assign rval_o = del_le ? right_val_i : val_q;
  assign rage_o = del_le ? right_age_i : age_q;
  assign rvld   = del_le ? right_vld_i : own_vld_i;
  assign gt_o   = !rvld || (rval_o > sample_i);

  always_comb begin
    if (!gt_o) begin
      val_d = rval_o;
      age_d = rage_o + AW'(1);
    end else if (left_gt_i) begin
      val_d = left_rval_i;
      age_d = left_rage_i + AW'(1);
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

/* hw/rtl/swmf_median.sv */
// ----------------------------------------------------------------------------
// swmf_median: middle pick and output register
// Selects the two middle slots of the window and registers their sum, which
// is twice the median for both odd and even window lengths.
// ----------------------------------------------------------------------------
module swmf_median import swmf_pkg::*; #(
  parameter int WINDOW_MAX = 16,
  parameter int SW         = 32,
  parameter int KW         = 5
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [KW-1:0]        k_i,
  input  logic signed [SW-1:0] vals_i [WINDOW_MAX],
  output median_t              median_o
);

  logic [KW-1:0]        lo_idx, hi_idx;
  logic signed [SW-1:0] lo_val, hi_val;
  logic signed [SW:0]   sum;
  median_t              median_q;

  assign lo_idx = (k_i - KW'(1)) >> 1;
  assign hi_idx = k_i >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (lo_idx == KW'(i)) lo_val = lo_val | vals_i[i];
      if (hi_idx == KW'(i)) hi_val = hi_val | vals_i[i];
    end
  end

  assign sum = (SW+1)'(lo_val) + (SW+1)'(hi_val);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      median_q <= OUT_W'(sum);
    end
  end

  assign median_o = median_q;

endmodule

/* hw/rtl/sliding_window_median_filter_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_filter_top: running median over the last K samples
//
//   channel  dir  payload                     request taken when
//   in_i     in   sample[31:0], first         in_i.valid && in_i.ready
//   out_o    out  median_times_two[32:0]      out_o.valid && out_o.ready
//   cfg_i    in   window_size[4:0]            cfg_i.valid && cfg_i.ready
//
// One sample per clock while in_i is ready. The cell row updates at the accepting
// edge; the median is then picked from the updated row and registered once the
// output register is free. in_i stalls only while a result waits behind a full
// output register that out_o does not drain. cfg_i is always ready. Reset
// empties the window and sets K to 3; the cell row itself needs no clearing.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_top import swmf_pkg::*; #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  swmf_stream_if.sink   in_i,
  swmf_stream_if.source out_o,
  swmf_stream_if.sink   cfg_i
);

  localparam int KW   = $clog2(WINDOW_MAX + 1);
  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMPW = (KW > CFG_W) ? KW : CFG_W;

  cfg_t                        ws_q;
  logic [KW-1:0]               k_eff, fill_q, fill_d, fill_eff;
  logic                        p_q, p_d, ov_q, ov_d;
  logic                        in_acc, cfg_acc, full, res, out_free, load;
  logic [CMPW-1:0]             ws_w;
  logic signed [SAMPLE_BITS-1:0] s;
  cell_ctrl_t                  ctrl;
  logic [AW-1:0]               age_last;

  logic signed [SAMPLE_BITS-1:0] val  [WINDOW_MAX];
  logic [AW-1:0]                 age  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rval [WINDOW_MAX];
  logic [AW-1:0]                 rage [WINDOW_MAX];
  logic                          gt   [WINDOW_MAX];
  logic                          dseen[WINDOW_MAX];
  logic                          vld  [WINDOW_MAX];

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  assign ws_w = CMPW'(ws_q);
  always_comb begin
    if (ws_q == '0) begin
      k_eff = KW'(1);
    end else if (ws_w > CMPW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = KW'(ws_w);
    end
  end

  assign out_free   = !ov_q || out_o.ready;
  assign load       = p_q && out_free;
  assign in_i.ready = !p_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  assign s        = in_i.data.sample[SAMPLE_BITS-1:0];
  assign fill_eff = in_i.data.first ? '0 : fill_q;
  assign full     = (fill_eff == k_eff);
  assign age_last = AW'(k_eff - KW'(1));
  assign res      = in_acc && (full || (fill_eff + KW'(1) == k_eff));

  assign ctrl.upd  = in_acc;
  assign ctrl.full = full;

  always_comb begin
    if (cfg_acc) begin
      fill_d = '0;
    end else if (in_acc) begin
      fill_d = full ? k_eff : fill_eff + KW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  assign p_d  = res ? 1'b1 : (load ? 1'b0 : p_q);
  assign ov_d = load ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= RESET_WINDOW_SIZE;
      fill_q <= '0;
      p_q    <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_acc) ws_q <= cfg_i.data;
      fill_q <= fill_d;
      p_q    <= p_d;
      ov_q   <= ov_d;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                          rv_n, dseen_p, gt_p;
    logic signed [SAMPLE_BITS-1:0] rvl_n, rvl_p;
    logic [AW-1:0]                 rag_n, rag_p;

    assign vld[i] = (KW'(i) < fill_eff);

    if (i == 0) begin : g_first
      assign dseen_p = 1'b0;
      assign gt_p    = 1'b0;
      assign rvl_p   = s;
      assign rag_p   = '0;
    end else begin : g_mid
      assign dseen_p = dseen[i-1];
      assign gt_p    = gt[i-1];
      assign rvl_p   = rval[i-1];
      assign rag_p   = rage[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign rv_n  = 1'b0;
      assign rvl_n = val[i];
      assign rag_n = age[i];
    end else begin : g_inner
      assign rv_n  = vld[i+1];
      assign rvl_n = val[i+1];
      assign rag_n = age[i+1];
    end

    swmf_cell #(
      .SW (SAMPLE_BITS),
      .AW (AW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sample_i    (s),
      .age_last_i  (age_last),
      .own_vld_i   (vld[i]),
      .right_vld_i (rv_n),
      .right_val_i (rvl_n),
      .right_age_i (rag_n),
      .del_seen_i  (dseen_p),
      .left_gt_i   (gt_p),
      .left_rval_i (rvl_p),
      .left_rage_i (rag_p),
      .val_o       (val[i]),
      .age_o       (age[i]),
      .rval_o      (rval[i]),
      .rage_o      (rage[i]),
      .gt_o        (gt[i]),
      .del_seen_o  (dseen[i])
    );
  end

  swmf_median #(
    .WINDOW_MAX (WINDOW_MAX),
    .SW         (SAMPLE_BITS),
    .KW         (KW)
  ) u_median (
    .clk_i    (clk_i),
    .load_i   (load),
    .k_i      (k_eff),
    .vals_i   (val),
    .median_o (out_o.data)
  );

  assign out_o.valid = ov_q;

`ifndef SYNTHESIS
  // window never holds more than K samples
  a_fill_le_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_eff) else $error("fill count above window size");

  // a full window always finds an expired sample to drop
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |-> dseen[WINDOW_MAX-1]) else $error("no expired sample found");

  // size write restarts the window
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (fill_q == '0)) else $error("window not cleared on size write");

  // output only goes valid from a pending result
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(p_q)) else $error("result without pending sample");
`endif

endmodule
